// ===== rtl/onewire_temp_sensor_reader_unit_macros.svh =====
// Assertion helpers for the top-level RTL.
`ifndef ONEWIRE_TEMP_SENSOR_READER_UNIT_MACROS_SVH
`define ONEWIRE_TEMP_SENSOR_READER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define OWTR_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("owtr assertion failed");
`define OWTR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("owtr assertion failed");
`else
`define OWTR_ASSERT(label, clk, rstn, prop)
`define OWTR_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

// ===== rtl/owtr_pkg.sv =====
package owtr_pkg;

    localparam int CfgAddrW = 5;
    localparam int CfgDataW = 32;

    localparam logic [7:0] CMD_SKIP_ROM  = 8'hCC;
    localparam logic [7:0] CMD_CONVERT   = 8'h44;
    localparam logic [7:0] CMD_READ_PAD  = 8'hBE;

    typedef enum logic [2:0] {
        REG_IDLE_HIGH     = 3'd0,
        REG_RESET_LOW     = 3'd1,
        REG_PRESENCE_WAIT = 3'd2,
        REG_SETTLE        = 3'd3,
        REG_PULSE         = 3'd4,
        REG_SLOT          = 3'd5,
        REG_CONVERSION    = 3'd6
    } reg_addr_t;

    typedef enum logic [11:0] {
        PH_IDLE     = 12'b0000_0000_0001,
        PH_R_HIGH   = 12'b0000_0000_0010,
        PH_R_LOW    = 12'b0000_0000_0100,
        PH_R_WAIT   = 12'b0000_0000_1000,
        PH_R_SETTLE = 12'b0000_0001_0000,
        PH_W_PULSE  = 12'b0000_0010_0000,
        PH_W_DATA   = 12'b0000_0100_0000,
        PH_W_GAP    = 12'b0000_1000_0000,
        PH_CONV     = 12'b0001_0000_0000,
        PH_RD_PULSE = 12'b0010_0000_0000,
        PH_RD_DATA  = 12'b0100_0000_0000,
        PH_DONE     = 12'b1000_0000_0000
    } phase_t;

    typedef struct packed {
        logic [15:0] idle_high_ticks;
        logic [15:0] reset_low_ticks;
        logic [15:0] presence_wait_ticks;
        logic [15:0] settle_ticks;
        logic [7:0]  pulse_ticks;
        logic [15:0] slot_ticks;
        logic [23:0] conversion_ticks;
    } cfg_t;

    typedef struct packed {
        logic       presence_seen;
        logic [7:0] temperature;
        logic       done_res;
        logic       busy_res;
        logic       drive_low;
    } res_t;

    localparam int ResW = $bits(res_t);

endpackage

// ===== rtl/owtr_cfg.sv =====
module owtr_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [owtr_pkg::CfgAddrW-1:0]  paddr,
    input  logic [owtr_pkg::CfgDataW-1:0]  pwdata,
    output logic [owtr_pkg::CfgDataW-1:0]  prdata,
    output logic                           pready,
    output owtr_pkg::cfg_t                 cfg
);

    owtr_pkg::cfg_t      cfg_reg;
    owtr_pkg::reg_addr_t sel;
    logic                wr_en;

    assign pready = 1'b1;
    assign sel    = owtr_pkg::reg_addr_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.idle_high_ticks     <= 16'd80;
            cfg_reg.reset_low_ticks     <= 16'd800;
            cfg_reg.presence_wait_ticks <= 16'd100;
            cfg_reg.settle_ticks        <= 16'd50;
            cfg_reg.pulse_ticks         <= 8'd1;
            cfg_reg.slot_ticks          <= 16'd50;
            cfg_reg.conversion_ticks    <= 24'd2000;
        end else if (wr_en) begin
            unique case (sel)
                owtr_pkg::REG_IDLE_HIGH:     cfg_reg.idle_high_ticks     <= pwdata[15:0];
                owtr_pkg::REG_RESET_LOW:     cfg_reg.reset_low_ticks     <= pwdata[15:0];
                owtr_pkg::REG_PRESENCE_WAIT: cfg_reg.presence_wait_ticks <= pwdata[15:0];
                owtr_pkg::REG_SETTLE:        cfg_reg.settle_ticks        <= pwdata[15:0];
                owtr_pkg::REG_PULSE:         cfg_reg.pulse_ticks         <= pwdata[7:0];
                owtr_pkg::REG_SLOT:          cfg_reg.slot_ticks          <= pwdata[15:0];
                owtr_pkg::REG_CONVERSION:    cfg_reg.conversion_ticks    <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (sel)
            owtr_pkg::REG_IDLE_HIGH:     prdata = {16'd0, cfg_reg.idle_high_ticks};
            owtr_pkg::REG_RESET_LOW:     prdata = {16'd0, cfg_reg.reset_low_ticks};
            owtr_pkg::REG_PRESENCE_WAIT: prdata = {16'd0, cfg_reg.presence_wait_ticks};
            owtr_pkg::REG_SETTLE:        prdata = {16'd0, cfg_reg.settle_ticks};
            owtr_pkg::REG_PULSE:         prdata = {24'd0, cfg_reg.pulse_ticks};
            owtr_pkg::REG_SLOT:          prdata = {16'd0, cfg_reg.slot_ticks};
            owtr_pkg::REG_CONVERSION:    prdata = {8'd0, cfg_reg.conversion_ticks};
            default:                     prdata = '0;
        endcase
    end

endmodule

// ===== rtl/owtr_seq.sv =====
module owtr_seq (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           advance,
    input  logic           start_req,
    input  logic           line_level,
    input  owtr_pkg::cfg_t cfg,
    output owtr_pkg::res_t res
);

    owtr_pkg::phase_t phase_reg, phase_next, cur_phase;
    logic [23:0] tick_reg, tick_next, cur_tick;
    logic        pass2_reg, pass2_next, cur_pass2;
    logic [2:0]  bit_reg, bit_next;
    logic        byte_sel_reg, byte_sel_next;
    logic [7:0]  shift_reg, shift_next, sh;
    logic [7:0]  first_reg, first_next;
    logic [7:0]  temp_reg, temp_next;
    logic        presence_reg, presence_next;
    logic [23:0] len_raw, len;
    logic        last;
    logic        kick;

    assign kick      = (phase_reg == owtr_pkg::PH_IDLE) && start_req;
    assign cur_phase = kick ? owtr_pkg::PH_R_HIGH : phase_reg;
    assign cur_tick  = kick ? 24'd0 : tick_reg;
    assign cur_pass2 = kick ? 1'b0 : pass2_reg;

    // Phase length from the matching register, zero counts as one tick
    always_comb begin
        len_raw = 24'd1;
        unique case (cur_phase) inside
            owtr_pkg::PH_R_HIGH:   len_raw = {8'd0, cfg.idle_high_ticks};
            owtr_pkg::PH_R_LOW:    len_raw = {8'd0, cfg.reset_low_ticks};
            owtr_pkg::PH_R_WAIT:   len_raw = {8'd0, cfg.presence_wait_ticks};
            owtr_pkg::PH_R_SETTLE: len_raw = {8'd0, cfg.settle_ticks};
            owtr_pkg::PH_W_PULSE,
            owtr_pkg::PH_RD_PULSE: len_raw = {16'd0, cfg.pulse_ticks};
            owtr_pkg::PH_W_DATA,
            owtr_pkg::PH_W_GAP,
            owtr_pkg::PH_RD_DATA:  len_raw = {8'd0, cfg.slot_ticks};
            owtr_pkg::PH_CONV:     len_raw = cfg.conversion_ticks;
            default:               len_raw = 24'd1;
        endcase
    end

    assign len  = (len_raw == 24'd0) ? 24'd1 : len_raw;
    assign last = ({1'b0, cur_tick} + 25'd1) >= {1'b0, len};

    // Read slot samples the bus on its first tick
    assign sh = ((cur_phase == owtr_pkg::PH_RD_DATA) && (cur_tick == 24'd0))
              ? {line_level, shift_reg[7:1]} : shift_reg;

    always_comb begin
        phase_next    = cur_phase;
        tick_next     = cur_tick;
        pass2_next    = cur_pass2;
        bit_next      = bit_reg;
        byte_sel_next = byte_sel_reg;
        shift_next    = sh;
        first_next    = first_reg;
        temp_next     = temp_reg;
        presence_next = presence_reg;
        res           = '0;

        if (cur_phase == owtr_pkg::PH_DONE) begin
            res.done_res    = 1'b1;
            res.temperature = temp_reg;
            phase_next      = owtr_pkg::PH_IDLE;
            tick_next       = 24'd0;
            pass2_next      = 1'b0;
        end else if (cur_phase != owtr_pkg::PH_IDLE) begin
            res.busy_res = 1'b1;
            if (cur_phase == owtr_pkg::PH_R_LOW || cur_phase == owtr_pkg::PH_W_PULSE
                || cur_phase == owtr_pkg::PH_RD_PULSE) begin
                res.drive_low = 1'b1;
            end
            if (cur_phase == owtr_pkg::PH_W_DATA) begin
                res.drive_low = ~shift_reg[0];
            end

            if (!last) begin
                tick_next = cur_tick + 24'd1;
            end else begin
                tick_next = 24'd0;
                unique case (cur_phase)
                    owtr_pkg::PH_R_HIGH:   phase_next = owtr_pkg::PH_R_LOW;
                    owtr_pkg::PH_R_LOW:    phase_next = owtr_pkg::PH_R_WAIT;
                    owtr_pkg::PH_R_WAIT: begin
                        presence_next = ~line_level;
                        phase_next    = owtr_pkg::PH_R_SETTLE;
                    end
                    owtr_pkg::PH_R_SETTLE: begin
                        byte_sel_next = 1'b0;
                        bit_next      = 3'd0;
                        shift_next    = owtr_pkg::CMD_SKIP_ROM;
                        phase_next    = owtr_pkg::PH_W_PULSE;
                    end
                    owtr_pkg::PH_W_PULSE:  phase_next = owtr_pkg::PH_W_DATA;
                    owtr_pkg::PH_W_DATA: begin
                        shift_next = {1'b0, sh[7:1]};
                        if (bit_reg != 3'd7) begin
                            bit_next   = bit_reg + 3'd1;
                            phase_next = owtr_pkg::PH_W_PULSE;
                        end else begin
                            phase_next = owtr_pkg::PH_W_GAP;
                        end
                    end
                    owtr_pkg::PH_W_GAP: begin
                        if (!byte_sel_reg) begin
                            byte_sel_next = 1'b1;
                            bit_next      = 3'd0;
                            shift_next    = cur_pass2 ? owtr_pkg::CMD_READ_PAD
                                                      : owtr_pkg::CMD_CONVERT;
                            phase_next    = owtr_pkg::PH_W_PULSE;
                        end else if (cur_pass2) begin
                            byte_sel_next = 1'b0;
                            bit_next      = 3'd0;
                            shift_next    = 8'd0;
                            phase_next    = owtr_pkg::PH_RD_PULSE;
                        end else begin
                            phase_next = owtr_pkg::PH_CONV;
                        end
                    end
                    owtr_pkg::PH_CONV: begin
                        pass2_next = 1'b1;
                        phase_next = owtr_pkg::PH_R_HIGH;
                    end
                    owtr_pkg::PH_RD_PULSE: phase_next = owtr_pkg::PH_RD_DATA;
                    owtr_pkg::PH_RD_DATA: begin
                        if (bit_reg != 3'd7) begin
                            bit_next   = bit_reg + 3'd1;
                            phase_next = owtr_pkg::PH_RD_PULSE;
                        end else if (!byte_sel_reg) begin
                            first_next    = sh;
                            byte_sel_next = 1'b1;
                            bit_next      = 3'd0;
                            shift_next    = 8'd0;
                            phase_next    = owtr_pkg::PH_RD_PULSE;
                        end else begin
                            // Integer part: low nibble of MSB byte over high nibble of LSB
                            temp_next  = {sh[3:0], first_reg[7:4]};
                            phase_next = owtr_pkg::PH_DONE;
                        end
                    end
                    default: phase_next = owtr_pkg::PH_IDLE;
                endcase
            end
        end
        res.presence_seen = presence_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= owtr_pkg::PH_IDLE;
            tick_reg     <= '0;
            pass2_reg    <= 1'b0;
            bit_reg      <= '0;
            byte_sel_reg <= 1'b0;
            shift_reg    <= '0;
            first_reg    <= '0;
            temp_reg     <= '0;
            presence_reg <= 1'b0;
        end else if (advance) begin
            phase_reg    <= phase_next;
            tick_reg     <= tick_next;
            pass2_reg    <= pass2_next;
            bit_reg      <= bit_next;
            byte_sel_reg <= byte_sel_next;
            shift_reg    <= shift_next;
            first_reg    <= first_next;
            temp_reg     <= temp_next;
            presence_reg <= presence_next;
        end
    end

endmodule

// ===== rtl/owtr_skid.sv =====
module owtr_skid (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [owtr_pkg::ResW-1:0]  in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [owtr_pkg::ResW-1:0]  out_data
);

    logic                      main_valid_reg;
    logic [owtr_pkg::ResW-1:0] main_data_reg;
    logic                      skid_valid_reg;
    logic [owtr_pkg::ResW-1:0] skid_data_reg;
    logic                      push, pop;

    assign in_ready  = ~skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;
    assign push      = in_valid && in_ready;
    assign pop       = main_valid_reg && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            // drain the parked beat first
            if (pop) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (main_valid_reg && !pop) begin
                skid_valid_reg <= 1'b1;
            end
            main_valid_reg <= 1'b1;
        end else if (pop) begin
            main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                main_data_reg <= skid_data_reg;
            end
        end else if (push) begin
            if (main_valid_reg && !pop) begin
                skid_data_reg <= in_data;
            end else begin
                main_data_reg <= in_data;
            end
        end
    end

endmodule

// ===== rtl/onewire_temp_sensor_reader_unit.sv =====
// Each result beat is registered in the output buffer before it is shown on m_tdata.
// Throughput: one tick beat per cycle unless the output buffer is full; its two entries
// keep input open while one result waits, so the sequencer state update sets the pace.
// Reset (aresetn low, synchronous): sequencer idle, counters and bytes
// cleared, config registers back to their defaults, output buffer empty.
`include "onewire_temp_sensor_reader_unit_macros.svh"

module onewire_temp_sensor_reader_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [0] start_req, [1] line_level
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [0] drive_low, [1] busy_res, [2] done_res, [10:3] temperature, [11] presence_seen
    output logic [15:0]                    m_tdata,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [owtr_pkg::CfgAddrW-1:0]  paddr,
    input  logic [owtr_pkg::CfgDataW-1:0]  pwdata,
    output logic [owtr_pkg::CfgDataW-1:0]  prdata,
    output logic                           pready
);

    owtr_pkg::cfg_t            cfg;
    owtr_pkg::res_t            res;
    logic                      advance;
    logic [owtr_pkg::ResW-1:0] out_bits;

    assign advance = s_tvalid && s_tready;

    owtr_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    owtr_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .start_req  (s_tdata[0]),
        .line_level (s_tdata[1]),
        .cfg        (cfg),
        .res        (res)
    );

    owtr_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_bits)
    );

    assign m_tdata = {4'd0, out_bits};

    `OWTR_ASSERT(a_stall_means_full, aclk, aresetn, !s_tready |-> m_tvalid)
    `OWTR_ASSERT(a_done_releases_bus, aclk, aresetn, res.done_res |-> (!res.busy_res && !res.drive_low))
    `OWTR_ASSERT_NEXT(a_beat_lands, aclk, aresetn, advance && !m_tvalid, m_tvalid)

endmodule

// ===== bench/onewire_read_checker.sv =====
module onewire_read_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [0] start_req, [1] line_level
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] drive_low, [1] busy_res, [2] done_res, [10:3] temperature, [11] presence_seen
    input  logic [15:0]                   m_tdata,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [owtr_pkg::CfgAddrW-1:0] paddr,
    input  logic [owtr_pkg::CfgDataW-1:0] pwdata,
    input  logic [owtr_pkg::CfgDataW-1:0] prdata,
    input  logic                          pready,
    output int                            expected_left,
    output int                            mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    import owtr_pkg::*;

    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_RST_HIGH,
        SEQ_RST_LOW,
        SEQ_PRESENCE,
        SEQ_SETTLE,
        SEQ_WR_PULSE,
        SEQ_WR_SLOT,
        SEQ_WR_GAP,
        SEQ_CONVERT,
        SEQ_RD_PULSE,
        SEQ_RD_SLOT,
        SEQ_DONE
    } seq_state_t;

    cfg_t        timing;
    seq_state_t  seq;
    bit          second_pass;
    int unsigned tick_cnt;
    logic [2:0]  bit_idx;
    logic [1:0]  byte_idx;
    logic [7:0]  shreg;
    logic [7:0]  first_byte;
    logic [7:0]  temp_hold;
    logic        presence;
    int          err_cnt;
    res_t        expected_ticks[$];

    function automatic void flag_error(input string msg);
        err_cnt++;
        if (err_cnt <= 10) begin
            $display("%0t ns: %s", $time, msg);
        end
    endfunction

    function automatic void store_cfg(input logic [2:0] idx, input logic [31:0] val);
        case (reg_addr_t'(idx))
            REG_IDLE_HIGH:     timing.idle_high_ticks     = val[15:0];
            REG_RESET_LOW:     timing.reset_low_ticks     = val[15:0];
            REG_PRESENCE_WAIT: timing.presence_wait_ticks = val[15:0];
            REG_SETTLE:        timing.settle_ticks        = val[15:0];
            REG_PULSE:         timing.pulse_ticks         = val[7:0];
            REG_SLOT:          timing.slot_ticks          = val[15:0];
            REG_CONVERSION:    timing.conversion_ticks    = val[23:0];
            default: ;
        endcase
    endfunction

    function automatic logic [31:0] cfg_value(input logic [2:0] idx);
        case (reg_addr_t'(idx))
            REG_IDLE_HIGH:     return 32'(timing.idle_high_ticks);
            REG_RESET_LOW:     return 32'(timing.reset_low_ticks);
            REG_PRESENCE_WAIT: return 32'(timing.presence_wait_ticks);
            REG_SETTLE:        return 32'(timing.settle_ticks);
            REG_PULSE:         return 32'(timing.pulse_ticks);
            REG_SLOT:          return 32'(timing.slot_ticks);
            REG_CONVERSION:    return 32'(timing.conversion_ticks);
            default:           return '0;
        endcase
    endfunction

    function automatic int unsigned ticks_of(input seq_state_t s);
        int unsigned n;
        case (s)
            SEQ_RST_HIGH:               n = timing.idle_high_ticks;
            SEQ_RST_LOW:                n = timing.reset_low_ticks;
            SEQ_PRESENCE:               n = timing.presence_wait_ticks;
            SEQ_SETTLE:                 n = timing.settle_ticks;
            SEQ_WR_PULSE, SEQ_RD_PULSE: n = timing.pulse_ticks;
            SEQ_WR_SLOT, SEQ_WR_GAP,
            SEQ_RD_SLOT:                n = timing.slot_ticks;
            SEQ_CONVERT:                n = timing.conversion_ticks;
            default:                    n = 1;
        endcase
        return (n == 0) ? 1 : n;
    endfunction

    function automatic void enter(input seq_state_t s);
        seq = s;
        tick_cnt = 0;
    endfunction

    function automatic void load_byte(input seq_state_t s, input logic [1:0] idx,
                                      input logic [7:0] val);
        byte_idx = idx;
        bit_idx = '0;
        shreg = val;
        enter(s);
    endfunction

    function automatic void finish_phase(input logic line);
        case (seq)
            SEQ_RST_HIGH: enter(SEQ_RST_LOW);
            SEQ_RST_LOW:  enter(SEQ_PRESENCE);
            SEQ_PRESENCE: begin
                presence = ~line;
                enter(SEQ_SETTLE);
            end
            SEQ_SETTLE:   load_byte(SEQ_WR_PULSE, 2'd0, CMD_SKIP_ROM);
            SEQ_WR_PULSE: enter(SEQ_WR_SLOT);
            SEQ_WR_SLOT: begin
                shreg = shreg >> 1;
                if (bit_idx != 3'd7) begin
                    bit_idx++;
                    enter(SEQ_WR_PULSE);
                end else begin
                    enter(SEQ_WR_GAP);
                end
            end
            SEQ_WR_GAP: begin
                if (byte_idx == 2'd0) begin
                    load_byte(SEQ_WR_PULSE, 2'd1, second_pass ? CMD_READ_PAD : CMD_CONVERT);
                end else if (second_pass) begin
                    load_byte(SEQ_RD_PULSE, 2'd0, 8'd0);
                end else begin
                    enter(SEQ_CONVERT);
                end
            end
            SEQ_CONVERT: begin
                second_pass = 1'b1;
                enter(SEQ_RST_HIGH);
            end
            SEQ_RD_PULSE: enter(SEQ_RD_SLOT);
            SEQ_RD_SLOT: begin
                if (bit_idx != 3'd7) begin
                    bit_idx++;
                    enter(SEQ_RD_PULSE);
                end else if (byte_idx == 2'd0) begin
                    first_byte = shreg;
                    load_byte(SEQ_RD_PULSE, 2'd1, 8'd0);
                end else begin
                    temp_hold = {shreg[3:0], first_byte[7:4]};
                    enter(SEQ_DONE);
                end
            end
            default: enter(SEQ_IDLE);
        endcase
    endfunction

    // One bus tick: returns the pin command and status the master shows for it.
    function automatic res_t advance_bus(input logic start, input logic line);
        res_t r;
        r = '0;
        if (seq == SEQ_IDLE && start) begin
            second_pass = 1'b0;
            enter(SEQ_RST_HIGH);
        end
        if (seq == SEQ_DONE) begin
            r.done_res = 1'b1;
            r.temperature = temp_hold;
            enter(SEQ_IDLE);
        end else if (seq != SEQ_IDLE) begin
            r.busy_res = 1'b1;
            case (seq)
                SEQ_RST_LOW, SEQ_WR_PULSE, SEQ_RD_PULSE: r.drive_low = 1'b1;
                SEQ_WR_SLOT: r.drive_low = ~shreg[0];
                SEQ_RD_SLOT: begin
                    if (tick_cnt == 0) begin
                        shreg = {line, shreg[7:1]};
                    end
                end
                default: ;
            endcase
            if (tick_cnt + 1 < ticks_of(seq)) begin
                tick_cnt++;
            end else begin
                finish_phase(line);
            end
        end
        r.presence_seen = presence;
        return r;
    endfunction

    always @(posedge aclk) begin
        res_t got;
        res_t want;
        logic [31:0] reg_val;
        if (!aresetn) begin
            timing.idle_high_ticks = 16'd80;
            timing.reset_low_ticks = 16'd800;
            timing.presence_wait_ticks = 16'd100;
            timing.settle_ticks = 16'd50;
            timing.pulse_ticks = 8'd1;
            timing.slot_ticks = 16'd50;
            timing.conversion_ticks = 24'd2000;
            seq = SEQ_IDLE;
            second_pass = 1'b0;
            tick_cnt = 0;
            bit_idx = '0;
            byte_idx = '0;
            shreg = '0;
            first_byte = '0;
            temp_hold = '0;
            presence = 1'b0;
            expected_ticks.delete();
        end else begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    store_cfg(paddr[4:2], pwdata);
                end else begin
                    reg_val = cfg_value(paddr[4:2]);
                    if (prdata !== reg_val) begin
                        flag_error($sformatf("register %0d readback: want %0h, got %0h",
                                             paddr[4:2], reg_val, prdata));
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                expected_ticks.push_back(advance_bus(s_tdata[0], s_tdata[1]));
            end
            if (m_tvalid && m_tready) begin
                got = res_t'(m_tdata[11:0]);
                if (expected_ticks.size() == 0) begin
                    flag_error($sformatf("result beat %h with nothing expected", m_tdata));
                end else begin
                    want = expected_ticks.pop_front();
                    if (got.drive_low !== want.drive_low || got.busy_res !== want.busy_res
                        || got.done_res !== want.done_res
                        || got.temperature !== want.temperature
                        || got.presence_seen !== want.presence_seen
                        || m_tdata[15:12] !== 4'd0) begin
                        flag_error($sformatf({"tick result: want drive %0b busy %0b done %0b",
                            " temp %02h presence %0b, got drive %0b busy %0b done %0b",
                            " temp %02h presence %0b pad %0h"},
                            want.drive_low, want.busy_res, want.done_res, want.temperature,
                            want.presence_seen, got.drive_low, got.busy_res, got.done_res,
                            got.temperature, got.presence_seen, m_tdata[15:12]));
                    end
                end
            end
        end
        expected_left <= expected_ticks.size();
        mismatches <= err_cnt;
    end

endmodule

// ===== bench/tb_onewire_temp_sensor_reader_unit.sv =====
module tb_onewire_temp_sensor_reader_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import owtr_pkg::*;

    localparam int          HALF_PERIOD     = 10;
    localparam int          CYCLE_LIMIT     = 1000000;
    localparam int          HOLD_OFF_CYCLES = 120;
    localparam logic [2:0]  UNMAPPED_IDX    = 3'd7;
    localparam logic [15:0] MAX16           = 16'hFFFF;
    localparam logic [7:0]  MAX8            = 8'hFF;
    localparam logic [23:0] MAX24           = 24'hFF_FFFF;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata = '0;    // [0] start_req, [1] line_level
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    // [0] drive_low, [1] busy_res, [2] done_res, [10:3] temperature, [11] presence_seen
    logic [15:0]         m_tdata;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [CfgAddrW-1:0] paddr = '0;
    logic [CfgDataW-1:0] pwdata = '0;
    logic [CfgDataW-1:0] prdata;
    logic                pready;

    int expected_left;
    int mismatches;
    bit hold_off_req = 1'b0;
    bit hold_off_done = 1'b0;
    int tx_calm = 0;

    always #(HALF_PERIOD) aclk = ~aclk;

    onewire_temp_sensor_reader_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    onewire_read_checker u_check (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .expected_left(expected_left), .mismatches(mismatches)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic bit squeezing();
        return hold_off_req && !hold_off_done;
    endfunction

    // Sender: call at a rising edge, returns at the edge that takes the beat.
    task automatic send_tick(input bit start, input bit line);
        int gap;
        bit ok;
        if (squeezing()) begin
            gap = 0;
        end else if (tx_calm > 0) begin
            tx_calm--;
            gap = 0;
        end else begin
            if ($urandom_range(0, 24) == 0) tx_calm = 50;
            gap = pick_gap();
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, line, start};
        do begin
            @(negedge aclk);
            ok = s_tready;
            @(posedge aclk);
        end while (!ok);
    endtask

    task automatic run_ticks(input int count, input int start_pct);
        for (int i = 0; i < count; i++) begin
            send_tick($urandom_range(0, 99) < start_pct, $urandom_range(0, 1));
        end
    endtask

    // Stop offering and hold until every tick result has come back.
    task automatic settle_bus();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_left != 0);
        repeat (2) @(posedge aclk);
    endtask

    task automatic apb_access(input bit wr, input logic [2:0] idx, input logic [31:0] val);
        bit rdy;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do begin
            @(negedge aclk);
            rdy = pready;
            @(posedge aclk);
        end while (!rdy);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic read_all();
        for (int i = REG_IDLE_HIGH; i <= REG_CONVERSION; i++) begin
            apb_access(1'b0, 3'(i), '0);
        end
    endtask

    task automatic program_timing(input int unsigned idle_hi, input int unsigned rst_lo,
                                  input int unsigned pres, input int unsigned settle,
                                  input int unsigned pulse, input int unsigned slot,
                                  input int unsigned conv);
        apb_access(1'b1, REG_IDLE_HIGH, idle_hi);
        apb_access(1'b1, REG_RESET_LOW, rst_lo);
        apb_access(1'b1, REG_PRESENCE_WAIT, pres);
        apb_access(1'b1, REG_SETTLE, settle);
        apb_access(1'b1, REG_PULSE, pulse);
        apb_access(1'b1, REG_SLOT, slot);
        apb_access(1'b1, REG_CONVERSION, conv);
        read_all();
    endtask

    task automatic program_small();
        program_timing($urandom_range(1, 3), $urandom_range(1, 3), $urandom_range(1, 3),
                       $urandom_range(1, 3), $urandom_range(1, 2), $urandom_range(1, 3),
                       $urandom_range(1, 6));
    endtask

    // Receiver: random ready gaps, calm stretches, and one long hold-off.
    initial begin : rx_side
        int idle_left;
        int calm_left;
        int hold_left;
        idle_left = 0;
        calm_left = 0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (squeezing() && hold_left == 0) hold_left = HOLD_OFF_CYCLES;
            if (hold_left > 0) begin
                hold_left--;
                if (hold_left == 0) hold_off_done = 1'b1;
                m_tready <= 1'b0;
            end else if (idle_left > 0) begin
                idle_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (calm_left > 0) begin
                    calm_left--;
                end else if ($urandom_range(0, 19) == 0) begin
                    calm_left = 40;
                end else begin
                    idle_left = pick_gap();
                end
            end
        end
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        read_all();

        // Idle ticks, a start, and a start while already busy, at reset timing.
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b0);
        settle_bus();

        // Shrink timing mid-phase so the long idle-high phase ends at once.
        program_timing(1, 1, 1, 1, 1, 1, 1);
        apb_access(1'b1, UNMAPPED_IDX, 32'hFFFF_FFFF);
        read_all();
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        for (int i = 0; i < 12; i++) begin
            send_tick(1'b1, i[0]);
        end
        run_ticks(300, 20);
        settle_bus();

        program_small();
        hold_off_req = 1'b1;
        run_ticks(300, 25);
        settle_bus();

        for (int k = 0; k < 3; k++) begin
            program_timing(MAX16, MAX16, MAX16, MAX16, MAX8, MAX16, MAX24);
            run_ticks(40, 30);
            settle_bus();
            program_small();
            run_ticks(100, 30);
            settle_bus();
        end

        program_timing($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(1, 8),
                       $urandom_range(1, 8), $urandom_range(1, 4), $urandom_range(1, 8),
                       $urandom_range(1, 20));
        run_ticks(130, 20);
        settle_bus();
        repeat (4) @(posedge aclk);

        if (mismatches == 0 && expected_left == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
